// File: rtl/setq_pkg.sv
// shared types, codes and constants of the sorted event timer queue
`timescale 1ns / 1ps
package setq_pkg;

    localparam int NUM_EVENTS_DEF = 32;
    localparam int ID_W           = 5;
    localparam int ID_SLOTS       = 32;
    localparam int DATA_W         = 32;
    localparam int AMT_W          = 31;

    localparam logic [AMT_W-1:0]  MAX_SLICE_RST = 31'd4194304;
    localparam logic [DATA_W-1:0] RATE_DIV_RST  = 32'd1;

    localparam logic REG_MAX_SLICE = 1'b0;
    localparam logic REG_RATE_DIV  = 1'b1;

    typedef enum logic [2:0] {
        CMD_SCHED_NOW  = 3'd0,
        CMD_SCHED_PREV = 3'd1,
        CMD_CANCEL     = 3'd2,
        CMD_CONSUME    = 3'd3,
        CMD_SLICE_END  = 3'd4,
        CMD_QUERY      = 3'd5,
        CMD_RESCALE    = 3'd6,
        CMD_FORCE_EXIT = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SLICE = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TSEL_ENTRY = 2'd0,
        TSEL_LEN   = 2'd1,
        TSEL_REM   = 2'd2
    } t_tsel;

    typedef enum logic [1:0] {
        DSRC_NEW  = 2'd0,
        DSRC_OLD  = 2'd1,
        DSRC_PROD = 2'd2
    } t_dsrc;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC,
        ST_SET,
        ST_RM_PRE,
        ST_RM,
        ST_INS_PRE,
        ST_INS,
        ST_SE_PRE,
        ST_SE,
        ST_EMIT,
        ST_RS_N,
        ST_RS_NW,
        ST_RS_O,
        ST_RS_OW,
        ST_RS_PRE,
        ST_RS_EL,
        ST_RS_MUL,
        ST_RS_DIV,
        ST_RS_DW,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic  latch_in;
        logic  consume;
        logic  force_exit;
        logic  set_dl;
        logic  pass_pre;
        logic  adv;
        logic  dl_entry;
        logic  rm_step;
        logic  rm_fin;
        logic  ins_step;
        logic  se_pre;
        logic  se_step;
        logic  se_fin;
        logic  emit_beat;
        logic  report_beat;
        logic  div_start;
        t_dsrc div_src;
        logic  lat_n;
        logic  lat_o;
        logic  rs_pre;
        logic  mul;
        logic  scale_wr;
        logic  sat;
        logic  sel_len;
        logic  sel_rem;
    } t_ctl;

    typedef struct packed {
        t_cmd  cmd;
        logic  id_ok;
        logic  pend;
        logic  at_end;
        logic  dl_pos;
        logic  emit_more;
        logic  div_done;
        logic  q_zero;
        logic  ovf;
        logic  out_free;
        t_tsel tsel;
    } t_sts;

endpackage

// File: rtl/sorted_event_timer_queue.sv
// top level of the sorted event timer queue
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   command, event_id, amount, old_rate, new_rate
//  output    out        o_out_valid / i_out_stall kind, fired_id, remaining, slice_len,
//                                                 slice_left, last
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item at a time; consume, force exit and query go from decode straight to the report beat
// schedule and cancel walk the sorted list once or twice, one entry a cycle
// slice end walks the list once, then sends one beat per expired id
// rescale runs the divider twice for the rates and once per pending positive
// deadline plus slice length and remaining, saturating where the quotient would overflow
// synchronous active-low reset clears deadlines, counters and the output stage at once
// a stalled output holds its beat; the sequencer waits for a free output register
`timescale 1ns / 1ps
module sorted_event_timer_queue #(
    parameter int NUM_EVENTS = setq_pkg::NUM_EVENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [setq_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_command,
    input  logic [setq_pkg::ID_W-1:0]     i_event_id,
    input  logic [setq_pkg::AMT_W-1:0]    i_amount,
    input  logic [setq_pkg::DATA_W-1:0]   i_old_rate,
    input  logic [setq_pkg::DATA_W-1:0]   i_new_rate,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [setq_pkg::ID_W-1:0]     o_fired_id,
    output logic signed [setq_pkg::DATA_W-1:0] o_remaining,
    output logic [setq_pkg::AMT_W-1:0]    o_slice_len,
    output logic signed [setq_pkg::DATA_W-1:0] o_slice_left,
    output logic                          o_last
);
    setq_pkg::t_ctl w_ctl;
    setq_pkg::t_sts w_sts;

    setq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    setq_dp #(
        .NUM_EVENTS (NUM_EVENTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_event_id   (i_event_id),
        .i_amount     (i_amount),
        .i_old_rate   (i_old_rate),
        .i_new_rate   (i_new_rate),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_fired_id   (o_fired_id),
        .o_remaining  (o_remaining),
        .o_slice_len  (o_slice_len),
        .o_slice_left (o_slice_left),
        .o_last       (o_last)
    );

    // a new item is never taken right after one is accepted
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // fired-event beats always precede the final beat
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == setq_pkg::KIND_FIRED |-> !o_last)
        else $error("fired beat marked last");

    // query answers are single final beats
    a_query_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == setq_pkg::KIND_QUERY |-> o_last)
        else $error("query answer not last");

    // no output beat is produced while the block is idle and empty
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && $past(!o_in_stall) && !$past(o_out_valid) |-> !o_out_valid)
        else $error("beat appeared while idle");
endmodule

// File: rtl/setq_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit 32 bits
`timescale 1ns / 1ps
module setq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [setq_pkg::DATA_W-1:0]   i_hi,
    input  logic [setq_pkg::DATA_W-1:0]   i_lo,
    input  logic [setq_pkg::DATA_W-1:0]   i_div,
    output logic                          o_done,
    output logic [setq_pkg::DATA_W-1:0]   o_quot
);
    localparam int W  = setq_pkg::DATA_W;
    localparam int SW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_dv;
    logic [SW-1:0] r_cnt;
    logic          r_done;
    logic [W:0]    w_t;
    logic [W:0]    w_diff;
    logic          w_ge;

    always_comb begin
        w_t    = {r_rem, r_q[W-1]};
        w_ge   = w_t >= {1'b0, r_dv};
        w_diff = w_t - {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= SW'(W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == SW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_q   <= i_lo;
            r_dv  <= i_div;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_t[W-1:0];
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/setq_ctrl.sv
// sequencer for the timer queue: walks passes and issues datapath commands
`timescale 1ns / 1ps
module setq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  setq_pkg::t_sts   i_sts,
    output setq_pkg::t_ctl   o_ctl
);
    setq_pkg::t_state r_state;
    setq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= setq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            setq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = setq_pkg::ST_DEC;
            end
            setq_pkg::ST_DEC: begin
                unique case (i_sts.cmd)
                    setq_pkg::CMD_SCHED_NOW, setq_pkg::CMD_SCHED_PREV: begin
                        n_state = i_sts.id_ok ? setq_pkg::ST_SET : setq_pkg::ST_REPORT;
                    end
                    setq_pkg::CMD_CANCEL: begin
                        n_state = (i_sts.id_ok && i_sts.pend) ? setq_pkg::ST_RM_PRE
                                                              : setq_pkg::ST_REPORT;
                    end
                    setq_pkg::CMD_SLICE_END: n_state = setq_pkg::ST_SE_PRE;
                    setq_pkg::CMD_RESCALE:   n_state = setq_pkg::ST_RS_N;
                    default:                 n_state = setq_pkg::ST_REPORT;
                endcase
            end
            setq_pkg::ST_SET: begin
                n_state = i_sts.pend ? setq_pkg::ST_RM_PRE : setq_pkg::ST_INS_PRE;
            end
            setq_pkg::ST_RM_PRE: n_state = setq_pkg::ST_RM;
            setq_pkg::ST_RM: begin
                if (i_sts.at_end) begin
                    n_state = (i_sts.cmd == setq_pkg::CMD_CANCEL) ? setq_pkg::ST_REPORT
                                                                 : setq_pkg::ST_INS_PRE;
                end
            end
            setq_pkg::ST_INS_PRE: n_state = setq_pkg::ST_INS;
            setq_pkg::ST_INS: begin
                if (i_sts.at_end) n_state = setq_pkg::ST_REPORT;
            end
            setq_pkg::ST_SE_PRE: n_state = setq_pkg::ST_SE;
            setq_pkg::ST_SE: begin
                if (i_sts.at_end) n_state = setq_pkg::ST_EMIT;
            end
            setq_pkg::ST_EMIT: begin
                if (!i_sts.emit_more) n_state = setq_pkg::ST_REPORT;
            end
            setq_pkg::ST_RS_N:  n_state = setq_pkg::ST_RS_NW;
            setq_pkg::ST_RS_NW: begin
                if (i_sts.div_done) n_state = setq_pkg::ST_RS_O;
            end
            setq_pkg::ST_RS_O:  n_state = setq_pkg::ST_RS_OW;
            setq_pkg::ST_RS_OW: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.q_zero ? setq_pkg::ST_REPORT : setq_pkg::ST_RS_PRE;
                end
            end
            setq_pkg::ST_RS_PRE: n_state = setq_pkg::ST_RS_EL;
            setq_pkg::ST_RS_EL: begin
                if (i_sts.at_end || i_sts.dl_pos) n_state = setq_pkg::ST_RS_MUL;
            end
            setq_pkg::ST_RS_MUL: n_state = setq_pkg::ST_RS_DIV;
            setq_pkg::ST_RS_DIV, setq_pkg::ST_RS_DW: begin
                if (i_sts.ovf || r_state == setq_pkg::ST_RS_DW) begin
                    if (i_sts.ovf || i_sts.div_done) begin
                        unique case (i_sts.tsel)
                            setq_pkg::TSEL_ENTRY: n_state = setq_pkg::ST_RS_EL;
                            setq_pkg::TSEL_LEN:   n_state = setq_pkg::ST_RS_MUL;
                            default:              n_state = setq_pkg::ST_REPORT;
                        endcase
                    end
                end else begin
                    n_state = setq_pkg::ST_RS_DW;
                end
            end
            setq_pkg::ST_REPORT: begin
                if (i_sts.out_free) n_state = setq_pkg::ST_IDLE;
            end
            default: n_state = setq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl      = '0;
        o_in_stall = (r_state != setq_pkg::ST_IDLE);
        unique case (r_state)
            setq_pkg::ST_IDLE: begin
                o_ctl.latch_in = i_in_valid;
            end
            setq_pkg::ST_DEC: begin
                o_ctl.consume    = (i_sts.cmd == setq_pkg::CMD_CONSUME);
                o_ctl.force_exit = (i_sts.cmd == setq_pkg::CMD_FORCE_EXIT);
            end
            setq_pkg::ST_SET: begin
                o_ctl.set_dl = 1'b1;
            end
            setq_pkg::ST_RM_PRE, setq_pkg::ST_INS_PRE: begin
                o_ctl.pass_pre = 1'b1;
            end
            setq_pkg::ST_RM: begin
                o_ctl.rm_step = !i_sts.at_end;
                o_ctl.adv     = !i_sts.at_end;
                o_ctl.rm_fin  = i_sts.at_end;
            end
            setq_pkg::ST_INS: begin
                o_ctl.dl_entry = 1'b1;
                o_ctl.ins_step = 1'b1;
                o_ctl.adv      = !i_sts.at_end;
            end
            setq_pkg::ST_SE_PRE: begin
                o_ctl.pass_pre = 1'b1;
                o_ctl.se_pre   = 1'b1;
            end
            setq_pkg::ST_SE: begin
                o_ctl.dl_entry = 1'b1;
                o_ctl.se_step  = !i_sts.at_end;
                o_ctl.adv      = !i_sts.at_end;
                o_ctl.se_fin   = i_sts.at_end;
            end
            setq_pkg::ST_EMIT: begin
                o_ctl.emit_beat = i_sts.emit_more && i_sts.out_free;
            end
            setq_pkg::ST_RS_N: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_src   = setq_pkg::DSRC_NEW;
            end
            setq_pkg::ST_RS_NW: begin
                o_ctl.lat_n = i_sts.div_done;
            end
            setq_pkg::ST_RS_O: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_src   = setq_pkg::DSRC_OLD;
            end
            setq_pkg::ST_RS_OW: begin
                o_ctl.lat_o = i_sts.div_done;
            end
            setq_pkg::ST_RS_PRE: begin
                o_ctl.pass_pre = 1'b1;
                o_ctl.rs_pre   = 1'b1;
            end
            setq_pkg::ST_RS_EL: begin
                o_ctl.dl_entry = 1'b1;
                o_ctl.sel_len  = i_sts.at_end;
                o_ctl.adv      = !i_sts.at_end && !i_sts.dl_pos;
            end
            setq_pkg::ST_RS_MUL: begin
                o_ctl.dl_entry = 1'b1;
                o_ctl.mul      = 1'b1;
            end
            setq_pkg::ST_RS_DIV, setq_pkg::ST_RS_DW: begin
                o_ctl.dl_entry = 1'b1;
                if (r_state == setq_pkg::ST_RS_DIV && !i_sts.ovf) begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_src   = setq_pkg::DSRC_PROD;
                end else if (i_sts.ovf || i_sts.div_done) begin
                    o_ctl.scale_wr = 1'b1;
                    o_ctl.sat      = i_sts.ovf && r_state == setq_pkg::ST_RS_DIV;
                    o_ctl.adv      = (i_sts.tsel == setq_pkg::TSEL_ENTRY);
                    o_ctl.sel_rem  = (i_sts.tsel == setq_pkg::TSEL_LEN);
                end
            end
            setq_pkg::ST_REPORT: begin
                o_ctl.report_beat = i_sts.out_free;
            end
            default: o_ctl = '0;
        endcase
    end
endmodule

// File: rtl/setq_dp.sv
// datapath: deadlines, sorted id list, slice counters, scaler and output stage
`timescale 1ns / 1ps
module setq_dp #(
    parameter int NUM_EVENTS = setq_pkg::NUM_EVENTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  setq_pkg::t_ctl                i_ctl,
    output setq_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [setq_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic [2:0]                    i_command,
    input  logic [setq_pkg::ID_W-1:0]     i_event_id,
    input  logic [setq_pkg::AMT_W-1:0]    i_amount,
    input  logic [setq_pkg::DATA_W-1:0]   i_old_rate,
    input  logic [setq_pkg::DATA_W-1:0]   i_new_rate,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [setq_pkg::ID_W-1:0]     o_fired_id,
    output logic signed [setq_pkg::DATA_W-1:0] o_remaining,
    output logic [setq_pkg::AMT_W-1:0]    o_slice_len,
    output logic signed [setq_pkg::DATA_W-1:0] o_slice_left,
    output logic                          o_last
);
    localparam int W   = setq_pkg::DATA_W;
    localparam int IW  = setq_pkg::ID_W;
    localparam int NS  = setq_pkg::ID_SLOTS;
    localparam int AW  = $clog2(NUM_EVENTS);
    localparam int CW  = $clog2(NUM_EVENTS + 1);
    localparam int FW  = $clog2(NS + 1);

    setq_pkg::t_cmd    r_cmd;
    logic [IW-1:0]     r_id;
    logic [setq_pkg::AMT_W-1:0] r_amt;
    logic [W-1:0]      r_newr;
    logic [W-1:0]      r_oldr;
    logic [W-1:0]      r_dl [NS];
    logic [NS-1:0]     r_pend;
    logic [IW-1:0]     r_ol [NUM_EVENTS];
    logic [IW-1:0]     r_rdata;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_wr;
    logic [IW-1:0]     r_carry;
    logic              r_ins;
    logic              r_pos0;
    logic [W-1:0]      r_newdl;
    logic [W-1:0]      r_len;
    logic [W-1:0]      r_rem;
    logic [W-1:0]      r_next;
    logic [W-1:0]      r_n;
    logic [W-1:0]      r_o;
    logic [2*W-1:0]    r_prod;
    logic              r_neg;
    setq_pkg::t_tsel   r_tsel;
    logic [IW-1:0]     r_fired [NS];
    logic [FW-1:0]     r_nf;
    logic [FW-1:0]     r_j;
    logic [setq_pkg::AMT_W-1:0] r_mslice;
    logic [W-1:0]      r_rdiv;
    logic              r_ovalid;
    setq_pkg::t_kind   r_kind;
    logic [IW-1:0]     r_fid;
    logic [W-1:0]      r_remain;
    logic [setq_pkg::AMT_W-1:0] r_slen;
    logic [W-1:0]      r_sleft;
    logic              r_last;

    logic [IW-1:0]     w_dsel;
    logic [W-1:0]      w_dl;
    logic [W-1:0]      w_amt;
    logic [W-1:0]      w_sched;
    logic [W-1:0]      w_se_d;
    logic              w_keep;
    logic              w_hit;
    logic              w_at_end;
    logic              w_head;
    logic              w_id_ok;
    logic              w_out_free;
    logic [W-1:0]      w_val;
    logic              w_vneg;
    logic [W-1:0]      w_mag;
    logic [W-1:0]      w_deff;
    logic [W-1:0]      w_dhi;
    logic [W-1:0]      w_dlo;
    logic [W-1:0]      w_ddiv;
    logic              w_div_done;
    logic [W-1:0]      w_quot;
    logic              w_big;
    logic [W-1:0]      w_smag;
    logic [W-1:0]      w_sres;
    logic [W-1:0]      w_qans;
    logic [CW-1:0]     w_i_inc;
    logic [AW-1:0]     w_raddr;
    logic              w_wen;
    logic [AW-1:0]     w_waddr;
    logic [IW-1:0]     w_wdata;

    always_comb begin
        w_dsel     = i_ctl.dl_entry ? r_rdata : r_id;
        w_dl       = r_dl[w_dsel];
        w_amt      = {1'b0, r_amt};
        w_sched    = (r_cmd == setq_pkg::CMD_SCHED_NOW) ? w_amt + (r_len - r_rem)
                                                        : w_dl + w_amt;
        w_se_d     = w_dl - r_len;
        w_keep     = $signed(w_se_d) > 0;
        w_hit      = $signed(r_newdl) < $signed(w_dl);
        w_at_end   = (r_i == r_cnt);
        w_head     = r_pos0 || (!r_ins && r_i == '0);
        w_id_ok    = {4'b0, r_id} < 9'(NUM_EVENTS);
        w_out_free = !r_ovalid || !i_out_stall;
        w_i_inc    = r_i + 1'b1;
        w_qans     = (w_id_ok && r_pend[r_id]) ? w_dl - (r_len - r_rem) : '1;
    end

    // rescale operand, sign handling and saturation
    always_comb begin
        case (r_tsel)
            setq_pkg::TSEL_LEN: w_val = r_len;
            setq_pkg::TSEL_REM: w_val = r_rem;
            default:            w_val = w_dl;
        endcase
        w_vneg = w_val[W-1];
        w_mag  = w_vneg ? (~w_val + 1'b1) : w_val;
        w_deff = (r_rdiv == '0) ? W'(1) : r_rdiv;
        case (i_ctl.div_src)
            setq_pkg::DSRC_NEW: begin
                w_dhi = '0; w_dlo = r_newr; w_ddiv = w_deff;
            end
            setq_pkg::DSRC_OLD: begin
                w_dhi = '0; w_dlo = r_oldr; w_ddiv = w_deff;
            end
            default: begin
                w_dhi = r_prod[2*W-1:W]; w_dlo = r_prod[W-1:0]; w_ddiv = r_o;
            end
        endcase
        w_big  = i_ctl.sat || (r_neg ? (w_quot > {1'b1, {(W-1){1'b0}}})
                                     : (w_quot > {1'b0, {(W-1){1'b1}}}));
        w_smag = w_big ? (r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                       : w_quot;
        w_sres = r_neg ? (~w_smag + 1'b1) : w_smag;
    end

    setq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_hi    (w_dhi),
        .i_lo    (w_dlo),
        .i_div   (w_ddiv),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // list write port
    always_comb begin
        w_wen   = 1'b0;
        w_waddr = r_i[AW-1:0];
        w_wdata = r_rdata;
        if (i_ctl.rm_step && r_rdata != r_id) begin
            w_wen   = 1'b1;
            w_waddr = r_wr[AW-1:0];
        end
        if (i_ctl.se_step && w_keep) begin
            w_wen   = 1'b1;
            w_waddr = r_wr[AW-1:0];
        end
        if (i_ctl.ins_step) begin
            if (w_at_end) begin
                w_wen   = 1'b1;
                w_wdata = r_ins ? r_carry : r_id;
            end else if (!r_ins && w_hit) begin
                w_wen   = 1'b1;
                w_wdata = r_id;
            end else if (r_ins) begin
                w_wen   = 1'b1;
                w_wdata = r_carry;
            end
        end
        if (i_ctl.pass_pre) begin
            w_raddr = '0;
        end else if (i_ctl.adv) begin
            w_raddr = w_i_inc[AW-1:0];
        end else begin
            w_raddr = r_i[AW-1:0];
        end
    end

    // sorted id list
    always_ff @(posedge i_clk) begin
        if (w_wen) r_ol[w_waddr] <= w_wdata;
        r_rdata <= r_ol[w_raddr];
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_dl[k] <= '0;
            r_pend   <= '0;
            r_cnt    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_mslice <= setq_pkg::MAX_SLICE_RST;
            r_rdiv   <= setq_pkg::RATE_DIV_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == setq_pkg::REG_MAX_SLICE) begin
                    r_mslice <= i_cfg_data[setq_pkg::AMT_W-1:0];
                end else begin
                    r_rdiv <= i_cfg_data;
                end
            end
            if (i_ctl.set_dl) r_dl[r_id] <= w_sched;
            if (i_ctl.consume) r_rem <= r_rem - w_amt;
            if (i_ctl.force_exit && $signed(r_rem) > 0) begin
                r_len <= r_len - r_rem;
                r_rem <= '0;
            end
            if (i_ctl.rm_fin) begin
                r_cnt        <= r_cnt - 1'b1;
                r_pend[r_id] <= 1'b0;
            end
            if (i_ctl.ins_step && w_at_end) begin
                r_cnt        <= r_cnt + 1'b1;
                r_pend[r_id] <= 1'b1;
                if (w_head) begin
                    r_len <= r_newdl;
                    r_rem <= r_rem - (r_len - r_newdl);
                end
            end
            if (i_ctl.se_step) begin
                r_dl[r_rdata] <= w_se_d;
                if (!w_keep) r_pend[r_rdata] <= 1'b0;
            end
            if (i_ctl.se_fin) begin
                r_cnt <= r_wr;
                r_len <= r_next;
                r_rem <= r_rem + r_next;
            end
            if (i_ctl.scale_wr) begin
                case (r_tsel)
                    setq_pkg::TSEL_LEN: r_len <= w_sres;
                    setq_pkg::TSEL_REM: r_rem <= w_sres;
                    default:            r_dl[r_rdata] <= w_sres;
                endcase
            end
            if (i_ctl.emit_beat || i_ctl.report_beat) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd  <= setq_pkg::t_cmd'(i_command);
            r_id   <= i_event_id;
            r_amt  <= i_amount;
            r_newr <= i_new_rate;
            r_oldr <= i_old_rate;
        end
        if (i_ctl.set_dl) r_newdl <= w_sched;
        if (i_ctl.pass_pre) begin
            r_i    <= '0;
            r_wr   <= '0;
            r_ins  <= 1'b0;
            r_pos0 <= 1'b0;
        end else if (i_ctl.adv) begin
            r_i <= w_i_inc;
        end
        if (i_ctl.rm_step && r_rdata != r_id) r_wr <= r_wr + 1'b1;
        if (i_ctl.ins_step && !w_at_end) begin
            if (!r_ins && w_hit) begin
                r_ins   <= 1'b1;
                r_pos0  <= (r_i == '0);
                r_carry <= r_rdata;
            end else if (r_ins) begin
                r_carry <= r_rdata;
            end
        end
        if (i_ctl.se_pre) begin
            r_next <= {1'b0, r_mslice};
            r_nf   <= '0;
            r_j    <= '0;
        end
        if (i_ctl.se_step) begin
            if (w_keep) begin
                r_wr <= r_wr + 1'b1;
                if ($signed(r_next) >= $signed(w_se_d)) r_next <= w_se_d;
            end else begin
                // expired ids wait here until the new slice is known
                r_fired[r_nf[FW-2:0]] <= r_rdata;
                r_nf <= r_nf + 1'b1;
            end
        end
        if (i_ctl.lat_n) r_n <= w_quot;
        if (i_ctl.lat_o) r_o <= w_quot;
        if (i_ctl.rs_pre)  r_tsel <= setq_pkg::TSEL_ENTRY;
        if (i_ctl.sel_len) r_tsel <= setq_pkg::TSEL_LEN;
        if (i_ctl.sel_rem) r_tsel <= setq_pkg::TSEL_REM;
        if (i_ctl.mul) begin
            r_prod <= w_mag * r_n;
            r_neg  <= w_vneg;
        end
        if (i_ctl.emit_beat) begin
            r_j      <= r_j + 1'b1;
            r_kind   <= setq_pkg::KIND_FIRED;
            r_fid    <= r_fired[r_j[FW-2:0]];
            r_remain <= '0;
            r_slen   <= r_len[setq_pkg::AMT_W-1:0];
            r_sleft  <= r_rem;
            r_last   <= 1'b0;
        end
        if (i_ctl.report_beat) begin
            if (r_cmd == setq_pkg::CMD_QUERY) begin
                r_kind   <= setq_pkg::KIND_QUERY;
                r_fid    <= r_id;
                r_remain <= w_qans;
            end else begin
                r_kind   <= setq_pkg::KIND_SLICE;
                r_fid    <= '0;
                r_remain <= '0;
            end
            r_slen  <= r_len[setq_pkg::AMT_W-1:0];
            r_sleft <= r_rem;
            r_last  <= 1'b1;
        end
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.id_ok     = w_id_ok;
        o_sts.pend      = r_pend[r_id];
        o_sts.at_end    = w_at_end;
        o_sts.dl_pos    = $signed(w_dl) > 0;
        o_sts.emit_more = r_j < r_nf;
        o_sts.div_done  = w_div_done;
        o_sts.q_zero    = (w_quot == '0);
        o_sts.ovf       = r_prod[2*W-1:W] >= r_o;
        o_sts.out_free  = w_out_free;
        o_sts.tsel      = r_tsel;
    end

    assign o_out_valid  = r_ovalid;
    assign o_kind       = r_kind;
    assign o_fired_id   = r_fid;
    assign o_remaining  = r_remain;
    assign o_slice_len  = r_slen;
    assign o_slice_left = r_sleft;
    assign o_last       = r_last;
endmodule
